### rtl/npas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npas_pkg
// Shared types and constants of the nand page access sequencer: request
// codes, bus cycle kinds, burst descriptors and nand command bytes.
// ----------------------------------------------------------------------------
package npas_pkg;

    localparam int ADDR_W      = 28;
    localparam int COUNT_W     = 29;
    localparam int COL_MAX_W   = 12;
    localparam int ROW_MAX_W   = 24;
    localparam int STEP_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // nand command bytes
    localparam logic [7:0] CMD_READ    = 8'h00;
    localparam logic [7:0] CMD_READ_GO = 8'h30;
    localparam logic [7:0] CMD_PROG    = 8'h80;
    localparam logic [7:0] CMD_PROG_GO = 8'h10;
    localparam logic [7:0] CMD_READ_ID = 8'h90;
    localparam logic [7:0] CMD_RESET   = 8'hff;
    localparam logic [7:0] ID_ADDR     = 8'h00;
    localparam logic [3:0] COL_HI_MASK = 4'hf;

    typedef enum logic [2:0] {
        ACT_READ    = 3'd0,
        ACT_PROG    = 3'd1,
        ACT_READ_ID = 3'd2,
        ACT_RESET   = 3'd3,
        ACT_DATA    = 3'd4,
        ACT_READY   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        KIND_SEL   = 3'd0,
        KIND_DESEL = 3'd1,
        KIND_CMD   = 3'd2,
        KIND_ADDR  = 3'd3,
        KIND_WR    = 3'd4,
        KIND_RD    = 3'd5,
        KIND_WAIT  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_PROG,
        MODE_RST
    } mode_t;

    typedef enum logic [1:0] {
        F_ACCEPT,
        F_SCALE,
        F_COMMIT
    } front_state_t;

    // one burst of bus cycles, as caused by a single input beat
    typedef enum logic [3:0] {
        SEQ_READ_START,
        SEQ_PROG_START,
        SEQ_READ_ID,
        SEQ_RESET,
        SEQ_RD,
        SEQ_RD_HEADER,
        SEQ_RD_DESEL,
        SEQ_WR,
        SEQ_WR_END,
        SEQ_PROG_NEXT,
        SEQ_DESEL
    } seq_t;

    typedef struct packed {
        seq_t                   seq;
        logic [COL_MAX_W-1:0]   column;
        logic [ROW_MAX_W-1:0]   row;
        logic [7:0]             data;
    } desc_t;

endpackage

### rtl/npas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npas_queue
// Small descriptor queue between the request front end and the cycle engine.
// ----------------------------------------------------------------------------
module npas_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  npas_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output npas_pkg::desc_t head,
    output logic           empty
);
    import npas_pkg::*;

    desc_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

### rtl/npas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npas_front
// Request front end: keeps the operation state and turns each beat into at most
// one burst descriptor; splits start addresses into column and row.
// ----------------------------------------------------------------------------
module npas_front #(
    parameter int PAGE_BYTES = 2048,
    parameter int ROW_BITS   = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    action,
    input  logic [npas_pkg::ADDR_W-1:0]   byte_address,
    input  logic [npas_pkg::COUNT_W-1:0]  byte_count,
    input  logic [7:0]                    data_byte,
    input  logic                          queue_full,
    output logic                          push,
    output npas_pkg::desc_t               push_desc
);
    import npas_pkg::*;

    localparam int COL_W   = $clog2(PAGE_BYTES);
    localparam int RECIP   = (1 << ADDR_W) / PAGE_BYTES;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = ADDR_W + RECIP_W;
    localparam int QUO_W   = ADDR_W + 1 - COL_W;

    front_state_t          fstate_reg, fstate_next;
    mode_t                 mode_reg, mode_next;
    logic [COL_W-1:0]      column_reg, column_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [COUNT_W-1:0]    left_reg, left_next;
    logic                  await_reg, await_next;

    // start request in flight through the column / row split
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  prog_reg, prog_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [ADDR_W-1:0]     base_reg, base_next;

    logic                  accept;
    logic [COL_W:0]        col_inc;
    logic                  page_end;
    logic [COUNT_W-1:0]    left_dec;
    logic [COL_W-1:0]      col_adv;
    logic [ROW_BITS-1:0]   row_adv;
    logic [QUO_W-1:0]      quo_est;
    logic [ADDR_W-1:0]     page_const;
    logic [ADDR_W-1:0]     rem;
    logic                  rem_over;
    logic [ADDR_W-1:0]     rem_fix;
    logic [QUO_W-1:0]      quo_fix;
    logic [COL_W-1:0]      start_col;
    logic [ROW_BITS-1:0]   start_row;

    function automatic desc_t make_desc(seq_t s, logic [COL_W-1:0] c,
                                        logic [ROW_BITS-1:0] r, logic [7:0] d);
        desc_t x;
        x.seq    = s;
        x.column = COL_MAX_W'(c);
        x.row    = ROW_MAX_W'(r);
        x.data   = d;
        return x;
    endfunction

    assign in_ready = (fstate_reg == F_ACCEPT) && !queue_full;
    assign accept   = in_valid && in_ready;

    // one byte further through the page
    assign col_inc  = {1'b0, column_reg} + 1'b1;
    assign page_end = col_inc == (COL_W + 1)'(PAGE_BYTES);
    assign left_dec = left_reg - 1'b1;
    assign col_adv  = page_end ? '0 : col_inc[COL_W-1:0];
    assign row_adv  = page_end ? row_reg + 1'b1 : row_reg;

    // address split: reciprocal estimate, then one correction step
    assign quo_est    = QUO_W'(prod_reg >> ADDR_W);
    assign page_const = ADDR_W'(PAGE_BYTES);
    assign rem        = addr_reg - base_reg;
    assign rem_over   = rem >= page_const;
    assign rem_fix    = rem_over ? rem - page_const : rem;
    assign quo_fix    = quo_reg + QUO_W'(rem_over);
    assign start_col  = COL_W'(rem_fix);
    assign start_row  = ROW_BITS'(quo_fix);

    always_comb
    begin
        fstate_next = fstate_reg;
        mode_next   = mode_reg;
        column_next = column_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        await_next  = await_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;
        prog_next   = prog_reg;
        prod_next   = prod_reg;
        quo_next    = quo_reg;
        base_next   = base_reg;
        push        = 1'b0;
        push_desc   = make_desc(SEQ_DESEL, column_reg, row_reg, data_byte);

        unique case (fstate_reg)
            F_ACCEPT:
            begin
                if (accept)
                begin
                    priority if (action == ACT_RESET)
                    begin
                        push       = 1'b1;
                        push_desc  = make_desc(SEQ_RESET, column_reg, row_reg, data_byte);
                        mode_next  = MODE_RST;
                        await_next = 1'b1;
                        left_next  = '0;
                    end
                    else if (action == ACT_READ || action == ACT_PROG ||
                             action == ACT_READ_ID)
                    begin
                        if (mode_reg == MODE_IDLE)
                        begin
                            if (action == ACT_READ_ID)
                            begin
                                push      = 1'b1;
                                push_desc = make_desc(SEQ_READ_ID, column_reg, row_reg,
                                                      data_byte);
                            end
                            else
                            begin
                                addr_next   = byte_address;
                                count_next  = byte_count;
                                prog_next   = action == ACT_PROG;
                                prod_next   = PROD_W'(byte_address) * PROD_W'(RECIP);
                                fstate_next = F_SCALE;
                            end
                        end
                    end
                    else if (action == ACT_DATA)
                    begin
                        if (!await_reg && mode_reg == MODE_READ)
                        begin
                            left_next   = left_dec;
                            column_next = col_adv;
                            row_next    = row_adv;
                            push        = 1'b1;
                            if (page_end || left_dec == '0)
                            begin
                                if (left_dec != '0)
                                begin
                                    push_desc  = make_desc(SEQ_RD_HEADER, col_adv, row_adv,
                                                           data_byte);
                                    await_next = 1'b1;
                                end
                                else
                                begin
                                    push_desc = make_desc(SEQ_RD_DESEL, col_adv, row_adv,
                                                          data_byte);
                                    mode_next = MODE_IDLE;
                                end
                            end
                            else
                            begin
                                push_desc = make_desc(SEQ_RD, col_adv, row_adv, data_byte);
                            end
                        end
                        else if (!await_reg && mode_reg == MODE_PROG)
                        begin
                            left_next   = left_dec;
                            column_next = col_adv;
                            row_next    = row_adv;
                            push        = 1'b1;
                            if (page_end || left_dec == '0)
                            begin
                                push_desc  = make_desc(SEQ_WR_END, col_adv, row_adv,
                                                       data_byte);
                                await_next = 1'b1;
                            end
                            else
                            begin
                                push_desc = make_desc(SEQ_WR, col_adv, row_adv, data_byte);
                            end
                        end
                    end
                    else if (action == ACT_READY)
                    begin
                        if (await_reg)
                        begin
                            await_next = 1'b0;
                            if (mode_reg == MODE_PROG && left_reg != '0)
                            begin
                                push      = 1'b1;
                                push_desc = make_desc(SEQ_PROG_NEXT, column_reg, row_reg,
                                                      data_byte);
                            end
                            else if (mode_reg == MODE_PROG || mode_reg == MODE_RST)
                            begin
                                push      = 1'b1;
                                push_desc = make_desc(SEQ_DESEL, column_reg, row_reg,
                                                      data_byte);
                                mode_next = MODE_IDLE;
                            end
                            else if (mode_reg != MODE_READ)
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                end
            end
            F_SCALE:
            begin
                quo_next    = quo_est;
                base_next   = ADDR_W'(quo_est) * page_const;
                fstate_next = F_COMMIT;
            end
            F_COMMIT:
            begin
                column_next = start_col;
                row_next    = start_row;
                left_next   = (count_reg == '0) ? COUNT_W'(1) : count_reg;
                mode_next   = prog_reg ? MODE_PROG : MODE_READ;
                await_next  = !prog_reg;
                push        = 1'b1;
                push_desc   = make_desc(prog_reg ? SEQ_PROG_START : SEQ_READ_START,
                                        start_col, start_row, data_byte);
                fstate_next = F_ACCEPT;
            end
            default:
            begin
                fstate_next = F_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg <= F_ACCEPT;
            mode_reg   <= MODE_IDLE;
            column_reg <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            await_reg  <= 1'b0;
        end
        else
        begin
            fstate_reg <= fstate_next;
            mode_reg   <= mode_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            await_reg  <= await_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        count_reg <= count_next;
        prog_reg  <= prog_next;
        prod_reg  <= prod_next;
        quo_reg   <= quo_next;
        base_reg  <= base_next;
    end

endmodule

### rtl/npas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npas_back
// Cycle engine: steps through the head descriptor one bus cycle per clock, while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module npas_back (
    input  logic            clk,
    input  logic            rst_n,
    input  npas_pkg::desc_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      cycle_kind,
    output logic [7:0]      cycle_value,
    output logic            last
);
    import npas_pkg::*;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic               valid_reg, valid_next;
    kind_t              kind_reg;
    logic [7:0]         value_reg;
    logic               last_reg;

    kind_t              kind;
    logic [7:0]         value;
    logic               fin;
    logic               load;

    function automatic logic [7:0] addr_byte(desc_t d, logic [STEP_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            STEP_W'(0): b = d.column[7:0];
            STEP_W'(1): b = {4'b0000, d.column[11:8] & COL_HI_MASK};
            STEP_W'(2): b = d.row[7:0];
            STEP_W'(3): b = d.row[15:8];
            default:    b = d.row[23:16];
        endcase
        return b;
    endfunction

    // cycle for the current step of the head burst
    always_comb
    begin
        kind  = KIND_SEL;
        value = 8'h00;
        fin   = 1'b0;
        unique case (head.seq)
            SEQ_READ_START, SEQ_RD_HEADER:
            begin
                priority if (step_reg == STEP_W'(0))
                begin
                    kind = (head.seq == SEQ_RD_HEADER) ? KIND_RD : KIND_SEL;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    kind  = KIND_CMD;
                    value = CMD_READ;
                end
                else if (step_reg <= STEP_W'(6))
                begin
                    kind  = KIND_ADDR;
                    value = addr_byte(head, step_reg - STEP_W'(2));
                end
                else if (step_reg == STEP_W'(7))
                begin
                    kind  = KIND_CMD;
                    value = CMD_READ_GO;
                end
                else
                begin
                    kind = KIND_WAIT;
                    fin  = 1'b1;
                end
            end
            SEQ_PROG_START:
            begin
                priority if (step_reg == STEP_W'(0))
                begin
                    kind = KIND_SEL;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    kind  = KIND_CMD;
                    value = CMD_PROG;
                end
                else
                begin
                    kind  = KIND_ADDR;
                    value = addr_byte(head, step_reg - STEP_W'(2));
                    fin   = step_reg >= STEP_W'(6);
                end
            end
            SEQ_PROG_NEXT:
            begin
                if (step_reg == STEP_W'(0))
                begin
                    kind  = KIND_CMD;
                    value = CMD_PROG;
                end
                else
                begin
                    kind  = KIND_ADDR;
                    value = addr_byte(head, step_reg - STEP_W'(1));
                    fin   = step_reg >= STEP_W'(5);
                end
            end
            SEQ_READ_ID:
            begin
                priority if (step_reg == STEP_W'(0))
                begin
                    kind = KIND_SEL;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    kind  = KIND_CMD;
                    value = CMD_READ_ID;
                end
                else if (step_reg == STEP_W'(2))
                begin
                    kind  = KIND_ADDR;
                    value = ID_ADDR;
                end
                else if (step_reg <= STEP_W'(7))
                begin
                    kind = KIND_RD;
                end
                else
                begin
                    kind = KIND_DESEL;
                    fin  = 1'b1;
                end
            end
            SEQ_RESET:
            begin
                priority if (step_reg == STEP_W'(0))
                begin
                    kind = KIND_SEL;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    kind  = KIND_CMD;
                    value = CMD_RESET;
                end
                else
                begin
                    kind = KIND_WAIT;
                    fin  = 1'b1;
                end
            end
            SEQ_RD:
            begin
                kind = KIND_RD;
                fin  = 1'b1;
            end
            SEQ_RD_DESEL:
            begin
                if (step_reg == STEP_W'(0))
                begin
                    kind = KIND_RD;
                end
                else
                begin
                    kind = KIND_DESEL;
                    fin  = 1'b1;
                end
            end
            SEQ_WR:
            begin
                kind  = KIND_WR;
                value = head.data;
                fin   = 1'b1;
            end
            SEQ_WR_END:
            begin
                priority if (step_reg == STEP_W'(0))
                begin
                    kind  = KIND_WR;
                    value = head.data;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    kind  = KIND_CMD;
                    value = CMD_PROG_GO;
                end
                else
                begin
                    kind = KIND_WAIT;
                    fin  = 1'b1;
                end
            end
            SEQ_DESEL:
            begin
                kind = KIND_DESEL;
                fin  = 1'b1;
            end
            default:
            begin
                kind = KIND_DESEL;
                fin  = 1'b1;
            end
        endcase
    end

    assign load = !empty && (!valid_reg || out_ready);
    assign pop  = load && fin;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = fin ? '0 : step_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind;
            value_reg <= value;
            last_reg  <= fin;
        end
    end

    assign out_valid   = valid_reg;
    assign cycle_kind  = kind_reg;
    assign cycle_value = value_reg;
    assign last        = last_reg;

endmodule

### rtl/nand_page_access_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nand_page_access_sequencer
// Turns large-page nand requests (read, program, read id, reset, data bytes,
// ready events) into a stream of bus cycles.
// ----------------------------------------------------------------------------
// throughput: one beat and one bus cycle per cycle while the queue has room and the output
//   is not stalled; a read or program start holds the input while the front end splits
//   its address into column and row, and each burst holds the cycle engine until its last cycle
// reset: asynchronous, active low; idle mode, counters cleared, queue and
//   output stage empty
module nand_page_access_sequencer #(
    parameter int PAGE_BYTES = 2048,
    parameter int ROW_BITS   = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [27:0] byte_address,
    input  logic [28:0] byte_count,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  cycle_kind,
    output logic [7:0]  cycle_value,
    output logic        last
);
    import npas_pkg::*;

    // front to back descriptor path
    logic   push;
    desc_t  push_desc;
    logic   queue_full;
    logic   pop;
    desc_t  head;
    logic   queue_empty;

    // front end: holds the operation state (mode, column, row, bytes left,
    // ready wait) and classifies every beat into at most one burst descriptor.
    // a read or program start passes through a scale and a commit state to split the byte address.
    npas_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .ROW_BITS   (ROW_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .byte_address (byte_address),
        .byte_count   (byte_count),
        .data_byte    (data_byte),
        .queue_full   (queue_full),
        .push         (push),
        .push_desc    (push_desc)
    );

    // short queue so a stalled bus side does not stop the front end at once
    npas_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    // cycle engine: walks the head burst one bus cycle per clock, while the output is not
    // stalled, into the output register, marking the final cycle of each burst with last
    npas_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cycle_kind  (cycle_kind),
        .cycle_value (cycle_value),
        .last        (last)
    );

endmodule

### tb/sv/tb_nand_page_access_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nand_page_access_sequencer
// Self-checking bench for the nand page access sequencer. A queue of request
// beats (directed corner cases, then well-formed read / program / read id /
// reset sequences with random content and some noise) feeds a clocked driver.
// A behavioural predictor turns every accepted beat into the
// bus cycles it should cause, and a clocked monitor checks each output beat
// in order. Both handshakes idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------
module tb_nand_page_access_sequencer;

    import npas_pkg::*;

    localparam int PAGE_BYTES = 2048;
    localparam int ROW_BITS   = 17;

    // spare request codes, the block should ignore them
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // cycles allowed after the last expected beat before the verdict
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic [2:0]  act;
        logic [27:0] addr;
        logic [28:0] count;
        logic [7:0]  data;
    } request_beat_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } bus_cycle_t;

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [2:0]  action       = '0;
    logic [27:0] byte_address = '0;
    logic [28:0] byte_count   = '0;
    logic [7:0]  data_byte    = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [2:0]  cycle_kind;
    logic [7:0]  cycle_value;
    logic        last;

    always #5 clk = ~clk;

    nand_page_access_sequencer #(
        .PAGE_BYTES (PAGE_BYTES),
        .ROW_BITS   (ROW_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .byte_address (byte_address),
        .byte_count   (byte_count),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cycle_kind   (cycle_kind),
        .cycle_value  (cycle_value),
        .last         (last)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    request_beat_t requests_pending[$];   // filled by the stimulus, drained by the driver
    bus_cycle_t    cycles_due[$];         // bus cycles predicted but not yet seen
    bus_cycle_t    burst[$];              // cycles caused by the beat being predicted
    int unsigned   requests_made  = 0;
    int unsigned   offered_cnt    = 0;    // beats put on the input port
    int unsigned   taken_cnt      = 0;    // beats accepted by the dut
    int unsigned   error_cnt      = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;

    // predictor's view of the sequencer
    mode_t                 seq_mode;
    logic [11:0]           seq_column;
    logic [ROW_BITS-1:0]   seq_row;
    logic [28:0]           bytes_left;
    logic                  wait_ready;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    task automatic add_cycle(input kind_t kind, input logic [7:0] value);
        bus_cycle_t c;
        c.kind  = kind;
        c.value = value;
        c.last  = 1'b0;
        burst.push_back(c);
    endtask

    // column low, column high nibble, then three row bytes
    task automatic add_address();
        logic [23:0] row_wide;
        row_wide = 24'(seq_row);
        add_cycle(KIND_ADDR, seq_column[7:0]);
        add_cycle(KIND_ADDR, {4'h0, seq_column[11:8] & COL_HI_MASK});
        add_cycle(KIND_ADDR, row_wide[7:0]);
        add_cycle(KIND_ADDR, row_wide[15:8]);
        add_cycle(KIND_ADDR, row_wide[23:16]);
    endtask

    task automatic add_read_header();
        add_cycle(KIND_CMD, CMD_READ);
        add_address();
        add_cycle(KIND_CMD, CMD_READ_GO);
        add_cycle(KIND_WAIT, 8'h00);
        wait_ready = 1'b1;
    endtask

    task automatic load_request(input request_beat_t b);
        seq_column = 12'(b.addr % PAGE_BYTES);
        seq_row    = ROW_BITS'(b.addr / PAGE_BYTES);
        bytes_left = (b.count == 0) ? 29'd1 : b.count;
    endtask

    // one byte moved; true at the end of a page or of the request
    function automatic bit step_byte();
        bit page_done;
        page_done  = 1'b0;
        bytes_left = bytes_left - 29'd1;
        seq_column = seq_column + 12'd1;
        if (seq_column >= PAGE_BYTES)
        begin
            seq_column = '0;
            seq_row    = seq_row + 1'b1;
            page_done  = 1'b1;
        end
        return page_done || bytes_left == 0;
    endfunction

    task automatic predict_bus_cycles(input request_beat_t b);
        burst.delete();
        case (b.act)
            ACT_RESET:
            begin
                // taken in any state, drops whatever was going on
                add_cycle(KIND_SEL, 8'h00);
                add_cycle(KIND_CMD, CMD_RESET);
                add_cycle(KIND_WAIT, 8'h00);
                seq_mode   = MODE_RST;
                wait_ready = 1'b1;
                bytes_left = '0;
            end
            ACT_READ, ACT_PROG, ACT_READ_ID:
            begin
                // starts outside idle are dropped
                if (seq_mode == MODE_IDLE)
                begin
                    add_cycle(KIND_SEL, 8'h00);
                    if (b.act == ACT_READ)
                    begin
                        load_request(b);
                        seq_mode = MODE_READ;
                        add_read_header();
                    end
                    else if (b.act == ACT_PROG)
                    begin
                        load_request(b);
                        seq_mode   = MODE_PROG;
                        wait_ready = 1'b0;
                        add_cycle(KIND_CMD, CMD_PROG);
                        add_address();
                    end
                    else
                    begin
                        add_cycle(KIND_CMD, CMD_READ_ID);
                        add_cycle(KIND_ADDR, ID_ADDR);
                        repeat (5) add_cycle(KIND_RD, 8'h00);
                        add_cycle(KIND_DESEL, 8'h00);
                    end
                end
            end
            ACT_DATA:
            begin
                if (!wait_ready && seq_mode == MODE_READ)
                begin
                    add_cycle(KIND_RD, 8'h00);
                    if (step_byte())
                    begin
                        if (bytes_left != 0)
                            add_read_header();
                        else
                        begin
                            add_cycle(KIND_DESEL, 8'h00);
                            seq_mode = MODE_IDLE;
                        end
                    end
                end
                else if (!wait_ready && seq_mode == MODE_PROG)
                begin
                    add_cycle(KIND_WR, b.data);
                    if (step_byte())
                    begin
                        add_cycle(KIND_CMD, CMD_PROG_GO);
                        add_cycle(KIND_WAIT, 8'h00);
                        wait_ready = 1'b1;
                    end
                end
            end
            ACT_READY:
            begin
                if (wait_ready)
                begin
                    wait_ready = 1'b0;
                    if (seq_mode == MODE_PROG && bytes_left != 0)
                    begin
                        add_cycle(KIND_CMD, CMD_PROG);
                        add_address();
                    end
                    else if (seq_mode == MODE_PROG || seq_mode == MODE_RST)
                    begin
                        add_cycle(KIND_DESEL, 8'h00);
                        seq_mode = MODE_IDLE;
                    end
                    else if (seq_mode != MODE_READ)
                        seq_mode = MODE_IDLE;
                end
            end
            default:
            begin
                // spare codes do nothing
            end
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            cycles_due.push_back(burst[i]);
    endtask

    // ------------------------------------------------------------------------
    // driver: new beats go up at the falling edge, held until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        request_beat_t b;
        if (rst_n)
        begin
            if (!in_valid || taken_cnt == offered_cnt)
            begin
                if (requests_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    b = requests_pending.pop_front();
                    in_valid     <= 1'b1;
                    action       <= b.act;
                    byte_address <= b.addr;
                    byte_count   <= b.count;
                    data_byte    <= b.data;
                    offered_cnt++;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // acceptance and output checking at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        request_beat_t b;
        bus_cycle_t    exp;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                b.act   = action;
                b.addr  = byte_address;
                b.count = byte_count;
                b.data  = data_byte;
                predict_bus_cycles(b);
                taken_cnt++;
            end
            if (out_valid && out_ready)
            begin
                if (cycles_due.size() == 0)
                    report($sformatf("unexpected bus cycle kind %0d value 0x%02h last %0b",
                                     cycle_kind, cycle_value, last));
                else
                begin
                    exp = cycles_due.pop_front();
                    if (cycle_kind !== exp.kind)
                        report($sformatf("cycle_kind %0d, expected %0d (%s)",
                                         cycle_kind, exp.kind, exp.kind.name()));
                    if (cycle_value !== exp.value)
                        report($sformatf("cycle_value 0x%02h, expected 0x%02h",
                                         cycle_value, exp.value));
                    if (last !== exp.last)
                        report($sformatf("last %0b, expected %0b", last, exp.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic [2:0] act, input logic [27:0] addr,
                             input logic [28:0] count, input logic [7:0] data);
        request_beat_t b;
        b.act   = act;
        b.addr  = addr;
        b.count = count;
        b.data  = data;
        requests_pending.push_back(b);
        requests_made++;
    endtask

    // beat whose payload fields carry only noise
    task automatic push_plain(input logic [2:0] act);
        push_beat(act, 28'($urandom), 29'($urandom), 8'($urandom));
    endtask

    // well-formed read: ready after every header, one data beat per byte
    task automatic gen_read(input logic [27:0] addr, input logic [28:0] count);
        int unsigned left;
        int unsigned col;
        int unsigned n;
        push_beat(ACT_READ, addr, count, 8'($urandom));
        left = (count == 0) ? 1 : count;
        col  = addr % PAGE_BYTES;
        while (left > 0)
        begin
            push_plain(ACT_READY);
            n = (left < PAGE_BYTES - col) ? left : PAGE_BYTES - col;
            repeat (n) push_plain(ACT_DATA);
            left -= n;
            col   = 0;
        end
    endtask

    // well-formed program: data for a page, then ready after the confirm
    task automatic gen_prog(input logic [27:0] addr, input logic [28:0] count);
        int unsigned left;
        int unsigned col;
        int unsigned n;
        push_beat(ACT_PROG, addr, count, 8'($urandom));
        left = (count == 0) ? 1 : count;
        col  = addr % PAGE_BYTES;
        while (left > 0)
        begin
            n = (left < PAGE_BYTES - col) ? left : PAGE_BYTES - col;
            repeat (n) push_plain(ACT_DATA);
            push_plain(ACT_READY);
            left -= n;
            col   = 0;
        end
    endtask

    // a third of the starts sit just short of a page boundary
    function automatic logic [27:0] pick_address();
        logic [27:0] a;
        a = 28'($urandom);
        if ($urandom_range(2) == 0)
            a = 28'(a - (a % PAGE_BYTES) + (PAGE_BYTES - $urandom_range(1, 6)));
        return a;
    endfunction

    function automatic logic [28:0] pick_count();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 29'd0;
        else if (r == 1)
            return 29'($urandom_range(7, 14));
        return 29'($urandom_range(1, 5));
    endfunction

    // any beats at all, then a reset and its ready to bring the block home
    task automatic gen_noise();
        if ($urandom_range(1) == 0)
        begin
            // huge request cut short by a reset
            push_beat($urandom_range(1) ? ACT_READ : ACT_PROG, pick_address(),
                      29'($urandom) | 29'h1000_0000, 8'($urandom));
            repeat ($urandom_range(1, 3)) push_plain(ACT_DATA);
            push_plain(ACT_READY);
            repeat ($urandom_range(0, 2)) push_plain(ACT_DATA);
        end
        else
            repeat ($urandom_range(2, 5)) push_plain(3'($urandom_range(7)));
        push_plain(ACT_RESET);
        push_plain(ACT_READY);
    endtask

    // wait for the driver to run dry and every predicted cycle to appear
    task automatic drain();
        while (requests_pending.size() != 0 || taken_cnt != offered_cnt)
            @(negedge clk);
        while (cycles_due.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned send_phase[5];
        int unsigned recv_phase[5];
        int unsigned target;
        int unsigned pick;

        send_phase = '{0, 68, 0, 6, 0};
        recv_phase = '{0, 0, 68, 6, 0};

        seq_mode   = MODE_IDLE;
        seq_column = '0;
        seq_row    = '0;
        bytes_left = '0;
        wait_ready = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed corner cases, no idling
        push_plain(ACT_READY);                        // stray ready while idle
        push_plain(ACT_DATA);                         // stray data while idle
        push_plain(ACT_SPARE_LO);
        push_plain(ACT_SPARE_HI);
        push_plain(ACT_RESET);
        push_plain(ACT_READY);                        // ends the reset with deselect
        push_plain(ACT_READ_ID);
        // last byte of a page, zero length taken as one byte
        push_beat(ACT_READ, 28'h0FF_FFFF, 29'd0, 8'h00);
        push_plain(ACT_DATA);                         // data while waiting for ready
        push_plain(ACT_READY);
        push_plain(ACT_DATA);
        // program across the end of the row space, row wraps to zero
        push_beat(ACT_PROG, 28'hFFF_FFFE, 29'd3, 8'h00);
        push_beat(ACT_DATA, 28'h000_0000, 29'd0, 8'hFF);
        push_beat(ACT_DATA, 28'hFFF_FFFF, 29'h1FFF_FFFF, 8'h00);
        push_plain(ACT_READ_ID);                      // start while busy
        push_plain(ACT_READY);
        push_beat(ACT_DATA, 28'h000_0000, 29'd0, 8'hA5);
        push_plain(ACT_READY);
        // largest count, abandoned by a reset mid request
        push_beat(ACT_READ, 28'h000_0000, 29'h1FFF_FFFF, 8'hFF);
        push_plain(ACT_PROG);                         // start while busy
        push_plain(ACT_READY);
        push_plain(ACT_DATA);
        push_plain(ACT_RESET);                        // reset while busy
        push_plain(ACT_READY);
        drain();

        // random phases, each ends with the sender held off until all is out
        foreach (send_phase[p])
        begin
            send_idle_pct  = send_phase[p];
            recv_stall_pct = recv_phase[p];
            target = requests_made + 24;
            while (requests_made < target)
            begin
                pick = $urandom_range(9);
                if (pick <= 3)
                    gen_read(pick_address(), pick_count());
                else if (pick <= 6)
                    gen_prog(pick_address(), pick_count());
                else if (pick == 7)
                    push_plain(ACT_READ_ID);
                else if (pick == 8)
                begin
                    push_plain(ACT_RESET);
                    push_plain(ACT_READY);
                end
                else
                    gen_noise();
            end
            drain();
        end

        // let any stray output show before the verdict
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_cnt == 0)
            $display("tb_nand_page_access_sequencer: clean");
        else
            $display("tb_nand_page_access_sequencer: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("tb_nand_page_access_sequencer: errors");
        $finish;
    end

endmodule
